// ----- sv/md5_pkg.sv -----
`default_nettype none
package md5_pkg;

    localparam int unsigned CountW = 61;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // zero filling stops at this word, one past the last zeroed: before the length, and before a second block
    localparam logic [4:0] ZERO_LIMIT_LEN = 5'd14;
    localparam logic [4:0] ZERO_LIMIT_END = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    // where the controller goes once a compression has been folded into the chain
    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_PAD,
        AFTER_SECOND,
        AFTER_OUT
    } after_t;

    typedef struct packed {
        logic byte_wr;
        logic mark_wr;
        logic zero_wr;
        logic len_wr;
        logic zp_load_mark;
        logic zp_clear;
        logic zp_inc;
        logic zero_to_end;
        logic comp_start;
        logic round_en;
        logic chain_add;
        logic msg_clear;
    } cmd_t;

    typedef struct packed {
        logic block_fill;
        logic pos_ge56;
        logic zp_done;
        logic round_last;
    } status_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;
            4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;
            4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;
            4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;
            4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;
            4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;
            4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;
            4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;
            4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by a round, arithmetic mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] i;
        logic [3:0] g;
        i = r[3:0];
        case (r[5:4])
            2'd0:    g = i;
            2'd1:    g = i * 4'd5 + 4'd1;
            2'd2:    g = i * 4'd3 + 4'd5;
            2'd3:    g = i * 4'd7;
            default: g = i;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage
`default_nettype wire

// ----- sv/md5_message_digest_core.sv -----
`default_nettype none
// channel   dir   signals                          request
// s_axis    in    tvalid tready tdata tuser tlast  one message byte or end mark
// m_axis    out   tvalid tready tdata              one 128-bit digest
//
// A plain byte is written into the block buffer. A byte that fills a block starts a compression
// (load, 64 rounds, chain update). End mark: the pad byte, then zero words one by one up to word
// 13, a check that they are done, the length and compression, and a load of the output register;
// a pad at byte 56 or later first zeros up to word 15 and compresses that block.
// Reset clears the control state and the chain; the block buffer is not cleared.
// A digest waits in the output register; the next digest then holds the input off until taken.
module md5_message_digest_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tuser,   // [0] byte_present
    input  wire logic         s_axis_tlast,   // end_of_message
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata    // [31:0] digest_word0, [63:32] digest_word1,
                                              // [95:64] digest_word2, [127:96] digest_word3
);

    md5_pkg::cmd_t    cmd;
    md5_pkg::status_t sts;
    logic             out_load;
    logic             out_free;
    logic [127:0]     digest;
    logic             out_valid_reg, out_valid_next;
    logic [127:0]     out_data_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .out_free   (out_free),
        .sts        (sts),
        .in_ready   (s_axis_tready),
        .out_load   (out_load),
        .cmd        (cmd)
    );

    md5_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (s_axis_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .digest  (digest)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= digest;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- sv/md5_ctrl.sv -----
`default_nettype none
module md5_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_present,
    input  wire logic             in_last,
    input  wire logic             out_free,
    input  wire md5_pkg::status_t sts,
    output logic                  in_ready,
    output logic                  out_load,
    output md5_pkg::cmd_t         cmd
);

    md5_pkg::state_t state_reg, state_next;
    md5_pkg::after_t after_reg, after_next;
    logic            two_blk_reg, two_blk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= md5_pkg::ST_IDLE;
            after_reg   <= md5_pkg::AFTER_IDLE;
            two_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            after_reg   <= after_next;
            two_blk_reg <= two_blk_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        two_blk_next    = two_blk_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;
        cmd             = '0;
        cmd.zero_to_end = two_blk_reg;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.byte_wr = in_present;
                    if (in_present && sts.block_fill)
                    begin
                        cmd.comp_start = 1'b1;
                        after_next = in_last ? md5_pkg::AFTER_PAD : md5_pkg::AFTER_IDLE;
                        state_next = md5_pkg::ST_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = md5_pkg::ST_MARK;
                    end
                end
            end
            md5_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (sts.round_last)
                begin
                    state_next = md5_pkg::ST_FINISH;
                end
            end
            md5_pkg::ST_FINISH:
            begin
                cmd.chain_add = 1'b1;
                case (after_reg)
                    md5_pkg::AFTER_IDLE:   state_next = md5_pkg::ST_IDLE;
                    md5_pkg::AFTER_PAD:    state_next = md5_pkg::ST_MARK;
                    md5_pkg::AFTER_SECOND:
                    begin
                        cmd.zp_clear = 1'b1;
                        two_blk_next = 1'b0;
                        state_next   = md5_pkg::ST_ZERO;
                    end
                    md5_pkg::AFTER_OUT:    state_next = md5_pkg::ST_OUT;
                    default:               state_next = md5_pkg::ST_IDLE;
                endcase
            end
            md5_pkg::ST_MARK:
            begin
                cmd.mark_wr      = 1'b1;
                cmd.zp_load_mark = 1'b1;
                two_blk_next     = sts.pos_ge56;
                state_next       = md5_pkg::ST_ZERO;
            end
            md5_pkg::ST_ZERO:
            begin
                if (sts.zp_done)
                begin
                    if (two_blk_reg)
                    begin
                        // no room for the length: close this block first
                        cmd.comp_start = 1'b1;
                        after_next     = md5_pkg::AFTER_SECOND;
                        state_next     = md5_pkg::ST_ROUND;
                    end
                    else
                    begin
                        state_next = md5_pkg::ST_LEN;
                    end
                end
                else
                begin
                    cmd.zero_wr = 1'b1;
                    cmd.zp_inc  = 1'b1;
                end
            end
            md5_pkg::ST_LEN:
            begin
                cmd.len_wr     = 1'b1;
                cmd.comp_start = 1'b1;
                after_next     = md5_pkg::AFTER_OUT;
                state_next     = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    cmd.msg_clear = 1'b1;
                    state_next    = md5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/md5_datapath.sv -----
`default_nettype none
module md5_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        in_byte,
    input  wire md5_pkg::cmd_t     cmd,
    output md5_pkg::status_t       sts,
    output logic [127:0]           digest
);

    logic [31:0] block_words_reg [16];

    logic [31:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [31:0] chain_a_next, chain_b_next, chain_c_next, chain_d_next;
    logic [31:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic [31:0] ra_next, rb_next, rc_next, rd_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [md5_pkg::CountW-1:0] count_reg, count_next;
    logic [4:0]  zp_reg, zp_next;

    logic [5:0]  pos;
    logic [3:0]  pos_word;
    logic [1:0]  pos_lane;
    logic [31:0] mark_word;
    logic [63:0] bit_len;
    logic [31:0] f_val;
    logic [31:0] m_val;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [31:0] new_b;

    assign pos      = count_reg[5:0];
    assign pos_word = pos[5:2];
    assign pos_lane = pos[1:0];
    assign bit_len  = {count_reg, 3'b000};

    // bytes below the end stay, the pad byte goes at the end, zeros above
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (2'(k) < pos_lane)
                mark_word[8*k +: 8] = block_words_reg[pos_word][8*k +: 8];
            else if (2'(k) == pos_lane)
                mark_word[8*k +: 8] = md5_pkg::PAD_BYTE;
            else
                mark_word[8*k +: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr)
            block_words_reg[pos_word][8*pos_lane +: 8] <= in_byte;
        else if (cmd.mark_wr)
            block_words_reg[pos_word] <= mark_word;
        else if (cmd.zero_wr)
            block_words_reg[zp_reg[3:0]] <= 32'h0;
        else if (cmd.len_wr)
        begin
            block_words_reg[14] <= bit_len[31:0];
            block_words_reg[15] <= bit_len[63:32];
        end
    end

    // one MD5 round
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (rb_reg & rc_reg) | (~rb_reg & rd_reg);
            2'd1:    f_val = (rb_reg & rd_reg) | (rc_reg & ~rd_reg);
            2'd2:    f_val = rb_reg ^ rc_reg ^ rd_reg;
            2'd3:    f_val = rc_reg ^ (rb_reg | ~rd_reg);
            default: f_val = 32'h0;
        endcase
        m_val   = block_words_reg[md5_pkg::msg_index(rnd_reg)];
        sum     = f_val + ra_reg + md5_pkg::round_k(rnd_reg) + m_val;
        rot_dbl = {sum, sum} << md5_pkg::rot_amt(rnd_reg);
        new_b   = rb_reg + rot_dbl[63:32];
    end

    always_comb
    begin
        ra_next = ra_reg;
        rb_next = rb_reg;
        rc_next = rc_reg;
        rd_next = rd_reg;
        if (cmd.comp_start)
        begin
            ra_next = chain_a_reg;
            rb_next = chain_b_reg;
            rc_next = chain_c_reg;
            rd_next = chain_d_reg;
        end
        else if (cmd.round_en)
        begin
            ra_next = rd_reg;
            rd_next = rc_reg;
            rc_next = rb_reg;
            rb_next = new_b;
        end
    end

    always_comb
    begin
        chain_a_next = chain_a_reg;
        chain_b_next = chain_b_reg;
        chain_c_next = chain_c_reg;
        chain_d_next = chain_d_reg;
        if (cmd.msg_clear)
        begin
            chain_a_next = md5_pkg::IV_A;
            chain_b_next = md5_pkg::IV_B;
            chain_c_next = md5_pkg::IV_C;
            chain_d_next = md5_pkg::IV_D;
        end
        else if (cmd.chain_add)
        begin
            chain_a_next = chain_a_reg + ra_reg;
            chain_b_next = chain_b_reg + rb_reg;
            chain_c_next = chain_c_reg + rc_reg;
            chain_d_next = chain_d_reg + rd_reg;
        end
    end

    always_comb
    begin
        rnd_next = rnd_reg;
        if (cmd.comp_start)
            rnd_next = 6'd0;
        else if (cmd.round_en)
            rnd_next = rnd_reg + 6'd1;

        count_next = count_reg;
        if (cmd.msg_clear)
            count_next = '0;
        else if (cmd.byte_wr)
            count_next = count_reg + md5_pkg::CountW'(1);

        zp_next = zp_reg;
        if (cmd.zp_load_mark)
            zp_next = {1'b0, pos_word} + 5'd1;
        else if (cmd.zp_clear)
            zp_next = 5'd0;
        else if (cmd.zp_inc)
            zp_next = zp_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_a_reg <= md5_pkg::IV_A;
            chain_b_reg <= md5_pkg::IV_B;
            chain_c_reg <= md5_pkg::IV_C;
            chain_d_reg <= md5_pkg::IV_D;
            rnd_reg     <= 6'd0;
            count_reg   <= '0;
            zp_reg      <= 5'd0;
        end
        else
        begin
            chain_a_reg <= chain_a_next;
            chain_b_reg <= chain_b_next;
            chain_c_reg <= chain_c_next;
            chain_d_reg <= chain_d_next;
            rnd_reg     <= rnd_next;
            count_reg   <= count_next;
            zp_reg      <= zp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        rc_reg <= rc_next;
        rd_reg <= rd_next;
    end

    assign sts.block_fill = (pos == 6'd63);
    assign sts.pos_ge56   = (pos[5:3] == 3'b111);
    assign sts.zp_done    = cmd.zero_to_end ? (zp_reg == md5_pkg::ZERO_LIMIT_END)
                                            : (zp_reg == md5_pkg::ZERO_LIMIT_LEN);
    assign sts.round_last = (rnd_reg == 6'd63);

    assign digest = {md5_pkg::swap_bytes(chain_d_reg), md5_pkg::swap_bytes(chain_c_reg),
                     md5_pkg::swap_bytes(chain_b_reg), md5_pkg::swap_bytes(chain_a_reg)};

endmodule
`default_nettype wire
